// ===== rtl/three_wire_rtc_serial_master_top_defines.svh =====
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master_top_defines
// Assertion macros for the three-wire serial master.
// ----------------------------------------------------------------------------
`ifndef THREE_WIRE_RTC_SERIAL_MASTER_TOP_DEFINES_SVH
`define THREE_WIRE_RTC_SERIAL_MASTER_TOP_DEFINES_SVH

// same-cycle implication
`define TWRSM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TWRSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/twrsm_pkg.sv =====
// ----------------------------------------------------------------------------
// twrsm_pkg
// Shared types and constants for the three-wire serial master.
// ----------------------------------------------------------------------------
package twrsm_pkg;

    localparam int BURST_BYTES_DEF = 8;
    localparam int BYTE_CNT_W      = 4;
    localparam int IN_TDATA_W      = 24;
    localparam int OUT_TDATA_W     = 24;

    localparam logic [7:0] CMD_SINGLE_WR = 8'h80;
    localparam logic [7:0] CMD_SINGLE_RD = 8'h81;
    localparam logic [7:0] CMD_BURST_WR  = 8'hBE;
    localparam logic [7:0] CMD_BURST_RD  = 8'hBF;

    typedef enum logic [1:0] {
        OP_SINGLE_WR = 2'd0,
        OP_SINGLE_RD = 2'd1,
        OP_BURST_WR  = 2'd2,
        OP_BURST_RD  = 2'd3
    } t_op;

    typedef struct packed {
        logic       cmd_valid;
        t_op        opcode;
        logic [7:0] cmd_byte;
        logic [7:0] wr_data;
        logic       wr_data_valid;
        logic       io_in;
    } t_item;

endpackage

// ===== rtl/twrsm_front.sv =====
// ----------------------------------------------------------------------------
// twrsm_front
// Unpacks tick transactions, builds the command byte, and queues them.
// ----------------------------------------------------------------------------
module twrsm_front
    import twrsm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_valid,
    output logic                  o_s_ready,
    input  logic [IN_TDATA_W-1:0] i_s_data,
    input  logic                  i_pop,
    output logic                  o_item_valid,
    output t_item                 o_item
);

    t_item       r_queue [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        push;
    logic        pop;
    t_item       in_item;
    logic [4:0]  reg_index;

    assign reg_index = i_s_data[7:3];

    always_comb begin
        in_item               = '0;
        in_item.cmd_valid     = i_s_data[0];
        in_item.opcode        = t_op'(i_s_data[2:1]);
        in_item.wr_data       = i_s_data[15:8];
        in_item.wr_data_valid = i_s_data[16];
        in_item.io_in         = i_s_data[17];
        case (in_item.opcode)
            OP_SINGLE_WR: in_item.cmd_byte = {2'b00, reg_index, 1'b0} | CMD_SINGLE_WR;
            OP_SINGLE_RD: in_item.cmd_byte = {2'b00, reg_index, 1'b0} | CMD_SINGLE_RD;
            OP_BURST_WR:  in_item.cmd_byte = CMD_BURST_WR;
            OP_BURST_RD:  in_item.cmd_byte = CMD_BURST_RD;
            default:      in_item.cmd_byte = CMD_BURST_RD;
        endcase
    end

    assign o_s_ready    = (r_count != 2'd2);
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_queue[r_rd_ptr];
    assign push         = i_s_valid && o_s_ready;
    assign pop          = i_pop && o_item_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= in_item;
        end
    end

endmodule

// ===== rtl/twrsm_back.sv =====
// ----------------------------------------------------------------------------
// twrsm_back
// Bus sequencer: advances one tick per queued transaction, drives results.
// ----------------------------------------------------------------------------
module twrsm_back
    import twrsm_pkg::*;
#(
    parameter int BURST_BYTES = BURST_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [7:0]             i_half_period,
    input  logic                   i_item_valid,
    input  t_item                  i_item,
    output logic                   o_pop,
    output logic                   o_m_valid,
    input  logic                   i_m_ready,
    output logic [OUT_TDATA_W-1:0] o_m_data
);

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_CMD  = 3'd1,
        PH_DATA = 3'd2,
        PH_WAIT = 3'd3,
        PH_END  = 3'd4
    } t_phase;

    localparam logic [BYTE_CNT_W:0] TOTAL_BURST = (BYTE_CNT_W+1)'(BURST_BYTES);

    t_phase                r_phase,   n_phase;
    logic [1:0]            r_kind,    n_kind;
    logic [7:0]            r_shift,   n_shift;
    logic [2:0]            r_bit,     n_bit;
    logic [BYTE_CNT_W-1:0] r_byte,    n_byte;
    logic [7:0]            r_div,     n_div;
    logic                  r_clk_lvl, n_clk_lvl;
    logic                  r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic                  reading;
    logic [7:0]            half;
    logic [7:0]            div_inc;
    logic                  elapsed;
    logic [BYTE_CNT_W:0]   byte_inc;
    logic [BYTE_CNT_W:0]   total;
    logic                  rd_valid;
    logic [7:0]            rd_byte;
    logic                  done;
    logic                  busy;
    logic                  drive;
    logic                  lvl;

    assign o_pop     = i_item_valid && (!r_out_valid || i_m_ready);
    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;

    assign reading  = r_kind[0];
    assign half     = (i_half_period == 8'd0) ? 8'd1 : i_half_period;
    assign div_inc  = r_div + 8'd1;
    assign elapsed  = (div_inc >= half);
    assign byte_inc = {1'b0, r_byte} + (BYTE_CNT_W+1)'(1);
    assign total    = r_kind[1] ? TOTAL_BURST : (BYTE_CNT_W+1)'(1);

    always_comb begin
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_shift   = r_shift;
        n_bit     = r_bit;
        n_byte    = r_byte;
        n_div     = r_div;
        n_clk_lvl = r_clk_lvl;
        rd_valid  = 1'b0;
        rd_byte   = 8'd0;
        done      = 1'b0;
        case (r_phase)
            PH_IDLE: begin
                if (i_item.cmd_valid) begin
                    n_kind    = i_item.opcode;
                    n_shift   = i_item.cmd_byte;
                    n_bit     = 3'd0;
                    n_byte    = '0;
                    n_div     = 8'd0;
                    n_clk_lvl = 1'b0;
                    n_phase   = PH_CMD;
                end
            end
            PH_WAIT: begin
                if (i_item.wr_data_valid) begin
                    n_shift   = i_item.wr_data;
                    n_bit     = 3'd0;
                    n_div     = 8'd0;
                    n_clk_lvl = 1'b0;
                    n_phase   = PH_DATA;
                end
            end
            PH_CMD, PH_DATA: begin
                n_div = elapsed ? 8'd0 : div_inc;
                if (elapsed) begin
                    if (!r_clk_lvl) begin
                        n_clk_lvl = 1'b1;
                        if (r_phase == PH_DATA && reading) begin
                            n_shift = {i_item.io_in, r_shift[7:1]};
                        end
                    end else begin
                        n_clk_lvl = 1'b0;
                        if (!(r_phase == PH_DATA && reading)) begin
                            n_shift = {1'b0, r_shift[7:1]};
                        end
                        n_bit = r_bit + 3'd1;
                        if (r_bit == 3'd7) begin
                            if (r_phase == PH_CMD) begin
                                if (reading) begin
                                    n_shift = 8'd0;
                                    n_phase = PH_DATA;
                                end else begin
                                    n_phase = PH_WAIT;
                                end
                            end else begin
                                if (reading) begin
                                    rd_valid = 1'b1;
                                    rd_byte  = r_shift;
                                    n_shift  = 8'd0;
                                end
                                if (byte_inc >= total) begin
                                    n_phase = PH_END;
                                end else begin
                                    n_byte = byte_inc[BYTE_CNT_W-1:0];
                                    if (!reading) begin
                                        n_phase = PH_WAIT;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            PH_END: begin
                n_div = elapsed ? 8'd0 : div_inc;
                if (elapsed) begin
                    n_phase   = PH_IDLE;
                    done      = 1'b1;
                    n_clk_lvl = 1'b0;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        busy  = (n_phase != PH_IDLE);
        drive = (n_phase == PH_CMD) || (n_phase == PH_WAIT) ||
                (n_phase == PH_DATA && !n_kind[0]);
        lvl   = ((n_phase == PH_CMD) || (n_phase == PH_DATA && !n_kind[0])) ?
                n_shift[0] : 1'b0;

        n_out_data        = '0;
        n_out_data[0]     = busy;
        n_out_data[1]     = busy && n_clk_lvl;
        n_out_data[2]     = lvl;
        n_out_data[3]     = drive;
        n_out_data[11:4]  = rd_byte;
        n_out_data[12]    = rd_valid;
        n_out_data[15:13] = busy ? n_byte[2:0] : 3'd0;
        n_out_data[16]    = (n_phase == PH_WAIT);
        n_out_data[17]    = busy;
        n_out_data[18]    = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_kind      <= 2'd0;
            r_shift     <= 8'd0;
            r_bit       <= 3'd0;
            r_byte      <= '0;
            r_div       <= 8'd0;
            r_clk_lvl   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_kind      <= n_kind;
                r_shift     <= n_shift;
                r_bit       <= n_bit;
                r_byte      <= n_byte;
                r_div       <= n_div;
                r_clk_lvl   <= n_clk_lvl;
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ===== rtl/three_wire_rtc_serial_master_top.sv =====
// An accepted input transaction is held in the two-entry queue, then registered as its result.
// Throughput: one tick transaction per cycle while m_axis_tready does not stall the result.
// Serial timing: each bus bit spans 2 x half_period_ticks accepted transactions (0 acts as 1).
// Reset: synchronous active-low; sequencer idle, queue empty, half period 1.
// ----------------------------------------------------------------------------
// three_wire_rtc_serial_master_top
// Three-wire clock-chip bus master, stepped one tick per input transaction.
// ----------------------------------------------------------------------------
`include "three_wire_rtc_serial_master_top_defines.svh"

module three_wire_rtc_serial_master_top
    import twrsm_pkg::*;
#(
    parameter int BURST_BYTES = BURST_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [7:0]             i_cfg_data,      // half_period_ticks
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [0] cmd_valid, [2:1] opcode, [7:3] reg_index, [15:8] wr_data,
    // [16] wr_data_valid, [17] io_in
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] chip_enable, [1] serial_clock, [2] io_out, [3] io_drive,
    // [11:4] rd_data, [12] rd_valid, [15:13] byte_index, [16] data_request,
    // [17] busy_res, [18] done_res
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [7:0] r_half_period;
    logic       item_valid;
    t_item      item;
    logic       pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= 8'd1;
        end else if (i_cfg_valid) begin
            r_half_period <= i_cfg_data;
        end
    end

    twrsm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_axis_tvalid),
        .o_s_ready    (s_axis_tready),
        .i_s_data     (s_axis_tdata),
        .i_pop        (pop),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    twrsm_back #(
        .BURST_BYTES (BURST_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_half_period (r_half_period),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_pop         (pop),
        .o_m_valid     (m_axis_tvalid),
        .i_m_ready     (m_axis_tready),
        .o_m_data      (m_axis_tdata)
    );

    `TWRSM_ASSERT_IMPL(a_rd_released, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[12], !m_axis_tdata[3] && !m_axis_tdata[2], "read byte reported while data pin driven")
    `TWRSM_ASSERT_IMPL(a_req_clk_low, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[16], m_axis_tdata[17] && m_axis_tdata[3] && !m_axis_tdata[1] && !m_axis_tdata[2], "data request outside clock-low driven wait")
    `TWRSM_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[18], !m_axis_tdata[0] && !m_axis_tdata[17] && !m_axis_tdata[1], "done with chip enable still high")
    `TWRSM_ASSERT_NEXT(a_pop_gives_out, i_clk, i_rst_n, pop, m_axis_tvalid, "sequencer step without result")

endmodule
